// ===== hw/rtl/kdpc_pkg.sv =====
// Shared types and constants for the key debounce press counter.
package kdpc_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [TickW-1:0] TickMax = '1;

  // Phase codes of the debounce machine.
  localparam logic [PhaseW-1:0] PH_IDLE    = 2'd0;
  localparam logic [PhaseW-1:0] PH_CONFIRM = 2'd1;
  localparam logic [PhaseW-1:0] PH_WAITREL = 2'd2;
  localparam logic [PhaseW-1:0] PH_LOCKOUT = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_LOCKOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_MODULUS   = 2'd2;

  localparam logic [TickW-1:0]  ConfirmDelayRst   = 16'd10;
  localparam logic [TickW-1:0]  ReleaseLockoutRst = 16'd500;
  localparam logic [CountW-1:0] CountModulusRst   = 8'd5;

  typedef struct packed {
    logic [TickW-1:0]  confirm_delay;
    logic [TickW-1:0]  release_lockout;
    logic [CountW-1:0] count_modulus;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [TickW-1:0]  tick_counter;
    logic [CountW-1:0] press_counter;
  } state_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              press_accepted;
    logic [CountW-1:0] press_count;
  } result_t;

endpackage

// ===== hw/rtl/key_debounce_press_counter_top.sv =====
// Top level of the key debounce press counter with input and result registers.
//
// Each input transfer is one millisecond tick carrying the sampled button level, and
// each tick yields exactly one result. A tick is captured in an input register, and
// the debounce step (tick counter, phase machine, press counter) runs as
// combinational logic between that register and the result register, where the
// state is updated as the tick moves on. One tick is accepted per clock cycle while
// the result side is not stalled; the result is written to the result register
// as the tick leaves the input register. Configuration writes take effect at once
// and are meant to be made while no tick is in flight.
module key_debounce_press_counter_top import kdpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] button_level
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] press_count, [8] press_accepted,
                                              // [10:9] phase
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    in_valid_q, level_q;
  logic    out_valid_q;
  logic    out_ready;
  logic    advance;

  kdpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kdpc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .level_i  (level_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The result register frees up when its content is transferred out.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.phase         <= PH_IDLE;
      state_q.tick_counter  <= '0;
      state_q.press_counter <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CountW - 1 - PhaseW){1'b0}}, res_q.phase,
                          res_q.press_accepted, res_q.press_count};

  a_accept_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.press_accepted |-> res_q.phase == PH_WAITREL)
    else $error("accepted press not followed by wait-release phase");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a tick moving on");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while both registers are full");

  a_idle_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.phase == PH_IDLE
    |=> state_q.phase == PH_IDLE || state_q.phase == PH_CONFIRM)
    else $error("idle phase left for a phase other than confirming");

endmodule

// ===== hw/rtl/kdpc_cfg.sv =====
// Configuration register file of the key debounce press counter.
module kdpc_cfg import kdpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CONFIRM_DELAY:   cfg_d.confirm_delay   = cfg_data_i;
        CFG_RELEASE_LOCKOUT: cfg_d.release_lockout = cfg_data_i;
        CFG_COUNT_MODULUS:   cfg_d.count_modulus   = cfg_data_i[CountW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_delay   <= ConfirmDelayRst;
      cfg_q.release_lockout <= ReleaseLockoutRst;
      cfg_q.count_modulus   <= CountModulusRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/kdpc_step.sv =====
// Next-state and result logic for one tick of the debounce machine.
module kdpc_step import kdpc_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic    level_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [TickW-1:0]  tick_inc;
  logic [CountW:0]   count_inc;
  logic              accepted;

  always_comb begin
    tick_inc  = (state_i.tick_counter == TickMax) ? TickMax
                                                  : state_i.tick_counter + 1'b1;
    count_inc = {1'b0, state_i.press_counter} + 1'b1;
    accepted  = 1'b0;
    state_o   = state_i;
    state_o.tick_counter = tick_inc;

    unique case (state_i.phase)
      PH_IDLE: begin
        if (level_i) begin
          state_o.tick_counter = '0;
          state_o.phase        = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (tick_inc >= cfg_i.confirm_delay) begin
          if (level_i) begin
            // Wrap to zero once the incremented count reaches the modulus.
            state_o.press_counter = (count_inc >= {1'b0, cfg_i.count_modulus})
                                    ? '0 : count_inc[CountW-1:0];
            accepted      = 1'b1;
            state_o.phase = PH_WAITREL;
          end else begin
            state_o.phase = PH_IDLE;
          end
        end
      end
      PH_WAITREL: begin
        if (!level_i) begin
          state_o.tick_counter = '0;
          state_o.phase        = PH_LOCKOUT;
        end
      end
      default: begin
        if (tick_inc >= cfg_i.release_lockout) begin
          state_o.phase = PH_IDLE;
        end
      end
    endcase

    result_o.press_count    = state_o.press_counter;
    result_o.press_accepted = accepted;
    result_o.phase          = state_o.phase;
  end

endmodule
